/* rtl/core/sdh_pkg.sv */
// Shared types, constants and round functions for the double SHA-256 hasher.
package sdh_pkg;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        final_word;
   } rsp_type;

   // Head of the byte queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      req_type data;
   } qhead_type;

   typedef enum logic [2:0] {
      S_LOAD,
      S_PAD,
      S_ROUND,
      S_ADD,
      S_OUT
   } state_type;

   localparam logic [7:0]  PAD_MARK   = 8'h80;
   localparam logic [63:0] DIGEST_LEN = 64'd256;

   function automatic logic [31:0] init_word(input logic [2:0] idx);
      case (idx)
         3'd0: init_word = 32'h6a09e667;
         3'd1: init_word = 32'hbb67ae85;
         3'd2: init_word = 32'h3c6ef372;
         3'd3: init_word = 32'ha54ff53a;
         3'd4: init_word = 32'h510e527f;
         3'd5: init_word = 32'h9b05688c;
         3'd6: init_word = 32'h1f83d9ab;
         3'd7: init_word = 32'h5be0cd19;
         default: init_word = 32'h6a09e667;
      endcase
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      case (idx)
         6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
         default: round_k = 32'h428a2f98;
      endcase
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

/* rtl/core/sdh_front.sv */
// Front end: byte intake queue between the request channel and the hash engine.
module sdh_front #(
   parameter int Depth = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sdh_pkg::req_type  req_data,
   output sdh_pkg::qhead_type head,
   input  logic              pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   sdh_pkg::req_type q_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push, do_pop;

   assign req_ready  = (count_ff != CntW'(Depth));
   assign push       = req_valid && req_ready;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

/* rtl/core/sdh_engine.sv */
// Back end: block buffer, padding sequencer, round unit and digest output register.
module sdh_engine (
   input  logic               clock,
   input  logic               reset,
   input  sdh_pkg::qhead_type head,
   output logic               pop,
   input  logic               csr_we,
   input  logic               csr_wdata,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sdh_pkg::rsp_type   rsp_data
);

   sdh_pkg::state_type state_ff, state_in;

   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] work_ff [8];
   logic [31:0] work_in [8];
   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  round_ff, round_in;
   logic [63:0] len_ff, len_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        mode_ff, pass_ff, pass_in, fin_ff, fin_in;
   logic        mark_ff, mark_in, late_ff, late_in, done_ff, done_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sdh_pkg::rsp_type rsp_ff, rsp_in;

   logic        load_wr, byte_wr, blk_full, out_load, len_slot;
   logic [7:0]  wr_byte, pad_byte, len_byte;
   logic [31:0] t1, t2, w_next;

   assign load_wr  = (state_ff == sdh_pkg::S_LOAD) && head.valid;
   assign byte_wr  = load_wr || (state_ff == sdh_pkg::S_PAD);
   assign blk_full = byte_wr && (fill_ff == 6'd63);
   assign out_load = !rsp_valid_ff || rsp_ready;
   assign pop      = load_wr;

   // Length bytes fill the last eight slots, most significant first.
   assign len_slot = (fill_ff[5:3] == 3'b111) && mark_ff && !late_ff;
   assign len_byte = 8'(len_ff >> {~fill_ff[2:0], 3'b000});
   assign pad_byte = !mark_ff ? sdh_pkg::PAD_MARK : (len_slot ? len_byte : 8'h00);
   assign wr_byte  = load_wr ? head.data.msg_byte : pad_byte;

   assign t1 = work_ff[7] + sdh_pkg::big_s1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + sdh_pkg::round_k(round_ff) + w_ff[0];
   assign t2 = sdh_pkg::big_s0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]));
   assign w_next = sdh_pkg::small_s1(w_ff[14]) + w_ff[9]
                 + sdh_pkg::small_s0(w_ff[1]) + w_ff[0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdh_pkg::S_LOAD: begin
            if (load_wr) begin
               if (fill_ff == 6'd63) begin
                  state_in = sdh_pkg::S_ROUND;
               end else if (head.data.is_last) begin
                  state_in = sdh_pkg::S_PAD;
               end
            end
         end
         sdh_pkg::S_PAD: begin
            if (fill_ff == 6'd63) begin
               state_in = sdh_pkg::S_ROUND;
            end
         end
         sdh_pkg::S_ROUND: begin
            if (round_ff == 6'd63) begin
               state_in = sdh_pkg::S_ADD;
            end
         end
         sdh_pkg::S_ADD: begin
            if (done_ff) begin
               state_in = (!pass_ff && mode_ff) ? sdh_pkg::S_PAD : sdh_pkg::S_OUT;
            end else begin
               state_in = fin_ff ? sdh_pkg::S_PAD : sdh_pkg::S_LOAD;
            end
         end
         sdh_pkg::S_OUT: begin
            if (out_load && (out_idx_ff == 3'd7)) begin
               state_in = sdh_pkg::S_LOAD;
            end
         end
         default: state_in = sdh_pkg::S_LOAD;
      endcase
   end

   always_comb begin
      w_in         = w_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      fill_in      = fill_ff;
      round_in     = round_ff;
      len_in       = len_ff;
      out_idx_in   = out_idx_ff;
      pass_in      = pass_ff;
      fin_in       = fin_ff;
      mark_in      = mark_ff;
      late_in      = late_ff;
      done_in      = done_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = out_load ? 1'b0 : rsp_valid_ff;

      if (byte_wr) begin
         w_in[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] = wr_byte;
         fill_in = fill_ff + 1'b1;
      end
      if (load_wr) begin
         len_in = len_ff + 64'd8;
         fin_in = head.data.is_last;
      end
      if (state_ff == sdh_pkg::S_PAD) begin
         if (!mark_ff) begin
            mark_in = 1'b1;
            late_in = (fill_ff[5:3] == 3'b111);
         end
         if (len_slot && (fill_ff == 6'd63)) begin
            done_in = 1'b1;
         end
      end
      if (blk_full) begin
         // Start a compression on the full block; a length that did not fit goes in the next one.
         round_in = '0;
         work_in  = chain_ff;
         late_in  = 1'b0;
      end

      case (state_ff)
         sdh_pkg::S_ROUND: begin
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[15]   = w_next;
            work_in[0] = t1 + t2;
            work_in[1] = work_ff[0];
            work_in[2] = work_ff[1];
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3] + t1;
            work_in[5] = work_ff[4];
            work_in[6] = work_ff[5];
            work_in[7] = work_ff[6];
            round_in   = round_ff + 1'b1;
         end
         sdh_pkg::S_ADD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            if (done_ff) begin
               done_in = 1'b0;
               if (!pass_ff && mode_ff) begin
                  // Feed the first digest back as a 32-byte message.
                  for (int i = 0; i < 8; i++) begin
                     w_in[i]     = chain_ff[i] + work_ff[i];
                     chain_in[i] = sdh_pkg::init_word(3'(i));
                  end
                  fill_in = 6'd32;
                  len_in  = sdh_pkg::DIGEST_LEN;
                  pass_in = 1'b1;
                  mark_in = 1'b0;
                  fin_in  = 1'b1;
               end
            end
         end
         sdh_pkg::S_OUT: begin
            if (out_load) begin
               rsp_valid_in       = 1'b1;
               rsp_in.digest_word = chain_ff[out_idx_ff];
               rsp_in.word_index  = out_idx_ff;
               rsp_in.final_word  = (out_idx_ff == 3'd7);
               out_idx_in         = out_idx_ff + 1'b1;
               if (out_idx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) begin
                     chain_in[i] = sdh_pkg::init_word(3'(i));
                  end
                  len_in  = '0;
                  fill_in = '0;
                  pass_in = 1'b0;
                  mark_in = 1'b0;
                  late_in = 1'b0;
                  fin_in  = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdh_pkg::S_LOAD;
         fill_ff      <= '0;
         round_ff     <= '0;
         len_ff       <= '0;
         out_idx_ff   <= '0;
         mode_ff      <= 1'b1;
         pass_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         late_ff      <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= sdh_pkg::init_word(3'(i));
         end
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         round_ff     <= round_in;
         len_ff       <= len_in;
         out_idx_ff   <= out_idx_in;
         pass_ff      <= pass_in;
         fin_ff       <= fin_in;
         mark_ff      <= mark_in;
         late_ff      <= late_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      work_ff <= work_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_round_to_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdh_pkg::S_ROUND) && (round_ff == 6'd63) |=> (state_ff == sdh_pkg::S_ADD))
      else $error("last round not followed by chain update");

   a_done_scope: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (state_ff == sdh_pkg::S_ROUND) || (state_ff == sdh_pkg::S_ADD))
      else $error("final-block flag outside compression");

   a_out_idx: assert property (@(posedge clock) disable iff (reset)
      (out_idx_ff != 3'd0) |-> (state_ff == sdh_pkg::S_OUT))
      else $error("digest word index pending outside output state");

   a_no_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sdh_pkg::S_LOAD) |-> !pop)
      else $error("byte taken while engine busy");

endmodule

/* rtl/core/sha256_double_hash.sv */
// Top level of the streaming SHA-256 / double SHA-256 hasher.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_data  (msg_byte, is_last)
//  rsp      out        rsp_valid / rsp_ready  rsp_data  (digest_word, word_index, final_word)
//  csr      in         csr_we                 csr_wdata (double_mode)
//
//  A block fills from the byte queue, and each compressed block takes 64 rounds
//  of the shared round unit and one chain update.
//  Padding writes one byte per cycle; the second hash compresses the padded first digest.
//  Digest words leave through an output register, one per cycle when not stalled.
//  Reset is synchronous; double_mode resets to 1 and the chain to the initial values.
//  The byte queue keeps taking input, up to QueueDepth bytes, while the engine
//  compresses or rsp stalls.
module sha256_double_hash #(
   parameter int QueueDepth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sdh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sdh_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_wdata
);

   sdh_pkg::qhead_type head;
   logic               pop;

   sdh_front #(
      .Depth(QueueDepth)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .head      (head),
      .pop       (pop)
   );

   sdh_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/sha256_double_hash_test.sv */
// Self-checking testbench for the streaming single / double SHA-256 hasher.
`timescale 1ns / 1ps

module sha256_double_hash_test;

   localparam int DRAIN_CYCLES = 400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TARGET_ITEMS = 230;

   localparam logic [31:0] K_TAB [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] IV_TAB [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sdh_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sdh_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic             csr_wdata = 1'b0;

   sha256_double_hash DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Predictor state
   logic [31:0]      chain [8];
   logic [7:0]       block_bytes [64];
   int               fill;
   logic [63:0]      msg_bits;
   logic             double_on;
   sdh_pkg::rsp_type digest_q [$];

   int  fail_count = 0;
   int  items_sent = 0;
   int  cycle_count = 0;
   bit  sender_idles = 1'b1;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void compress(inout logic [31:0] h[8], input logic [7:0] blk[64]);
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (int j = 0; j < 8; j++) v[j] = h[j];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int j = 7; j > 0; j--) v[j] = v[j-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) h[j] = h[j] + v[j];
   endfunction

   // Append the 0x80 mark, zeros and the big-endian bit length, then compress.
   function automatic void pad_and_close(inout logic [31:0] h[8], input logic [7:0] blk_in[64],
                                         input int used, input logic [63:0] bits);
      logic [7:0] blk [64];
      blk = blk_in;
      blk[used] = 8'h80;
      for (int i = used + 1; i < 64; i++) blk[i] = 8'h00;
      if (used > 55) begin
         compress(h, blk);
         for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      compress(h, blk);
   endfunction

   function automatic void hasher_restart();
      chain = IV_TAB;
      fill = 0;
      msg_bits = '0;
   endfunction

   function automatic void absorb_byte(input sdh_pkg::req_type item);
      logic [31:0]      first [8];
      logic [31:0]      second [8];
      logic [7:0]       blk2 [64];
      sdh_pkg::rsp_type word;
      block_bytes[fill] = item.msg_byte;
      fill++;
      msg_bits = msg_bits + 64'd8;
      if (fill == 64) begin
         compress(chain, block_bytes);
         fill = 0;
      end
      if (!item.is_last) return;
      first = chain;
      pad_and_close(first, block_bytes, fill, msg_bits);
      second = first;
      if (double_on) begin
         for (int i = 0; i < 64; i++) blk2[i] = 8'h00;
         for (int i = 0; i < 8; i++)
            {blk2[4*i], blk2[4*i+1], blk2[4*i+2], blk2[4*i+3]} = first[i];
         second = IV_TAB;
         pad_and_close(second, blk2, 32, 64'd256);
      end
      for (int i = 0; i < 8; i++) begin
         word.digest_word = second[i];
         word.word_index  = 3'(i);
         word.final_word  = (i == 7);
         digest_q.push_back(word);
      end
      hasher_restart();
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = sender_idles ? $urandom_range(0, 16) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.msg_byte = b;
      req_data.is_last  = last;
      do @(posedge clock); while (!req_ready);
      absorb_byte(req_data);
      items_sent++;
   endtask

   task automatic send_message(input int len);
      sender_idles = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
   endtask

   // Hold the sender until every digest word is out and the engine has settled.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      drain();
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = m;
      @(negedge clock);
      csr_we = 1'b0;
      double_on = m;
   endtask

   // Receiver: random stall before each digest word, with quiet stretches.
   initial begin
      int gap;
      int quiet;
      quiet = 0;
      forever begin
         if (quiet > 0) begin
            quiet--;
            gap = 0;
         end else if ($urandom_range(0, 7) == 0) begin
            quiet = $urandom_range(8, 40);
            gap = 0;
         end else begin
            gap = $urandom_range(0, 16);
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_q.size() == 0) begin
            $error("digest word with no transaction pending: %h", rsp_data.digest_word);
            fail_count++;
         end else begin
            sdh_pkg::rsp_type exp_word;
            exp_word = digest_q.pop_front();
            if (rsp_data.digest_word !== exp_word.digest_word) begin
               $error("digest_word expected %h actual %h",
                      exp_word.digest_word, rsp_data.digest_word);
               fail_count++;
            end
            if (rsp_data.word_index !== exp_word.word_index) begin
               $error("word_index expected %0d actual %0d",
                      exp_word.word_index, rsp_data.word_index);
               fail_count++;
            end
            if (rsp_data.final_word !== exp_word.final_word) begin
               $error("final_word expected %0d actual %0d",
                      exp_word.final_word, rsp_data.final_word);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sha256_double_hash_test failed");
         $finish;
      end
   end

   // Single-byte messages at the byte extremes and a two-byte message, with the reset mode (double).
   task automatic test_default_mode();
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7f, 1'b1);
   endtask

   // Plain SHA-256, including the classic "abc" message, then "abc" again in double mode.
   task automatic test_single_mode();
      write_mode(1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h63, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      write_mode(1'b1);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h63, 1'b1);
   endtask

   // Lengths at the block edges: 55 just fits the padding, 63 spills into an extra block, 64 fills one exactly.
   task automatic test_block_edges();
      int lens [3] = '{55, 63, 64};
      foreach (lens[i]) begin
         if ($urandom_range(0, 2) == 0) write_mode(logic'($urandom_range(0, 1)));
         send_message(lens[i]);
      end
   endtask

   task automatic test_random_messages();
      while (items_sent < TARGET_ITEMS) begin
         if ($urandom_range(0, 5) == 0) write_mode(logic'($urandom_range(0, 1)));
         send_message($urandom_range(0, 9) == 0 ? $urandom_range(40, 70)
                                                : $urandom_range(1, 12));
      end
   endtask

   initial begin
      double_on = 1'b1;
      hasher_restart();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_default_mode();
      test_single_mode();
      test_block_edges();
      test_random_messages();
      drain();
      if (fail_count == 0) begin
         $display("sha256_double_hash_test passed");
      end else begin
         $display("sha256_double_hash_test failed");
      end
      $finish;
   end

endmodule
